// ----- rtl/bal_pkg.sv -----
// ============================================================================
// bal_pkg - shared types for the bounded array list
// Request codes, status codes and the per-cell shift command.
// ============================================================================
package bal_pkg;

    // Request codes carried on the mode field
    typedef enum logic [2:0] {
        MODE_APPEND       = 3'd0,
        MODE_REMOVE_LAST  = 3'd1,
        MODE_INSERT_FRONT = 3'd2,
        MODE_REMOVE_FRONT = 3'd3,
        MODE_READ         = 3'd4,
        MODE_INSERT_AT    = 3'd5,
        MODE_DELETE_AT    = 3'd6
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Shift command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // open a gap at the target index
        logic del;  // close the gap at the target index
    } t_cell_cmd;

endpackage

// ----- rtl/bal_cell.sv -----
// ============================================================================
// bal_cell - one element slot of the list chain
// Holds one byte and loads from its left neighbor, its right neighbor or the
// new value, depending on the broadcast command and its own index.
// ============================================================================
module bal_cell #(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  bal_pkg::t_cell_cmd  i_cmd,
    input  logic [IDX_W-1:0]    i_at,
    input  logic [IDX_W-1:0]    i_rd_at,
    input  logic [7:0]          i_value,
    input  logic [7:0]          i_left,
    input  logic [7:0]          i_right,
    output logic [7:0]          o_data,
    output logic [7:0]          o_rd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [7:0] r_data;
    logic [7:0] n_data;

    // Pick the next byte: shift up above the target, load at it, shift down
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_IDX > i_at) begin
                n_data = i_left;
            end else if (MY_IDX == i_at) begin
                n_data = i_value;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_at) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Drive the byte onto the read bus only when this cell is addressed
    assign o_data = r_data;
    assign o_rd   = (MY_IDX == i_rd_at) ? r_data : 8'd0;

endmodule

// ----- rtl/bounded_array_list_core.sv -----
// ============================================================================
// bounded_array_list_core - ordered byte list with indexed insert and delete
// A chain of cells keeps the list packed from index 0; one request a cycle while the result is not stalled.
// ============================================================================
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+---------------------------------
//  request  | i_in_valid  | o_in_ready  | i_mode, i_position, i_value
//  result   | o_out_valid | i_out_ready | o_status, o_read_value, o_count
//
//  Every request completes at its transfer edge: any shift moves all cells in parallel
//  at that edge and the result lands in the output register at the same edge.
//  A new request is taken while the result register is empty or being drained.
//  Reset clears the count and the output valid; cell contents stay unknown.
//  A stalled result holds its register and stops further request transfers.
//
module bounded_array_list_core #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic [5:0] i_position,
    input  logic [7:0] i_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_read_value,
    output logic [6:0] o_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    bal_pkg::t_status   r_status;
    bal_pkg::t_status   n_status;
    logic [7:0]         r_read_value;
    logic [7:0]         n_read_value;

    bal_pkg::t_cell_cmd cmd;
    logic [IDX_W-1:0]   at;
    logic [IDX_W-1:0]   rd_at;
    logic               in_xfer;
    logic               full;
    logic               empty;
    logic               pos_range;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;

    logic [7:0] cell_data [CAPACITY];
    logic [7:0] cell_rd   [CAPACITY];
    logic [7:0] rd_bus;

    // Accept a request when the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Check list bounds against the current count
    assign full      = (r_count >= CAP_CNT);
    assign empty     = (r_count == '0);
    assign pos_ext   = CMP_W'(i_position);
    assign cnt_ext   = CMP_W'(r_count);
    assign pos_range = (pos_ext >= cnt_ext);
    assign rd_at     = IDX_W'(i_position);

    // Decode the request into a shift command, new count and status
    always_comb begin
        cmd          = '0;
        at           = '0;
        n_count      = r_count;
        n_status     = bal_pkg::ST_OK;
        n_read_value = 8'd0;
        unique case (i_mode)
            bal_pkg::MODE_APPEND: begin
                if (full) begin
                    n_status = bal_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    at      = IDX_W'(r_count);
                    n_count = r_count + 1'b1;
                end
            end
            bal_pkg::MODE_REMOVE_LAST: begin
                if (empty) begin
                    n_status = bal_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            bal_pkg::MODE_INSERT_FRONT: begin
                if (full) begin
                    n_status = bal_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            bal_pkg::MODE_REMOVE_FRONT: begin
                if (empty) begin
                    n_status = bal_pkg::ST_EMPTY;
                end else begin
                    cmd.del = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            bal_pkg::MODE_READ: begin
                if (pos_range) begin
                    n_status = bal_pkg::ST_RANGE;
                end else begin
                    n_read_value = rd_bus;
                end
            end
            bal_pkg::MODE_INSERT_AT: begin
                if (full) begin
                    n_status = bal_pkg::ST_FULL;
                end else if (pos_range) begin
                    n_status = bal_pkg::ST_RANGE;
                end else begin
                    cmd.ins = 1'b1;
                    at      = IDX_W'(i_position);
                    n_count = r_count + 1'b1;
                end
            end
            bal_pkg::MODE_DELETE_AT: begin
                if (empty) begin
                    n_status = bal_pkg::ST_EMPTY;
                end else if (pos_range) begin
                    n_status = bal_pkg::ST_RANGE;
                end else begin
                    cmd.del = 1'b1;
                    at      = IDX_W'(i_position);
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = bal_pkg::ST_OK;
            end
        endcase
        // Drop the command when no request transfers
        if (!in_xfer) begin
            cmd = '0;
        end
    end

    // Build the cell chain; the ends see zero neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [7:0] left_d;
        logic [7:0] right_d;
        if (g == 0) begin : g_lo
            assign left_d = 8'd0;
        end else begin : g_lo_n
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign right_d = 8'd0;
        end else begin : g_hi_n
            assign right_d = cell_data[g+1];
        end
        bal_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_at    (at),
            .i_rd_at (rd_at),
            .i_value (i_value),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[g]),
            .o_rd    (cell_rd[g])
        );
    end

    // Merge the read bus; only the addressed cell drives nonzero
    always_comb begin
        rd_bus = 8'd0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // Update the count on each request transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_xfer) begin
            r_count <= n_count;
        end
    end

    // Hold the result until the result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_count      = 7'(r_count);

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("element count exceeds capacity");

    a_count_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_count))
        else $error("count changed without a request transfer");

    a_result_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (o_out_valid && o_count == 7'(r_count)))
        else $error("result count does not match list count");

    a_read_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_value != 8'd0) |-> (o_status == bal_pkg::ST_OK))
        else $error("read data returned with error status");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bal_pkg::ST_FULL) |-> (r_count == CAP_CNT))
        else $error("full status while list not full");
`endif

endmodule
